// ----- sv/vertex_triple_dedup_indexer_top_defines.svh -----
// Assertion helpers shared by the RTL files of the vertex triple indexer.
`ifndef VERTEX_TRIPLE_DEDUP_INDEXER_TOP_DEFINES_SVH
`define VERTEX_TRIPLE_DEDUP_INDEXER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VTDI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define VTDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- sv/vtdi_pkg.sv -----
`default_nettype none

package vtdi_pkg;

    // Table geometry.
    localparam int unsigned TABLE_DEPTH = 4096;
    localparam int unsigned ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_BITS    = ADDR_BITS + 1;

    // Reference and key widths.
    localparam int unsigned REF_BITS = 20;
    localparam int unsigned KEY_BITS = 3 * REF_BITS;

    // Fixed result field widths.
    localparam int unsigned VIDX_BITS = 12;
    localparam int unsigned VCNT_BITS = 13;

    localparam logic [CNT_BITS-1:0] COUNT_FULL = CNT_BITS'(TABLE_DEPTH);

    // Item kinds.
    localparam logic KIND_CORNER = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [REF_BITS-1:0] position_index;
        logic [REF_BITS-1:0] texcoord_index;
        logic [REF_BITS-1:0] normal_ref;
    } item_t;

    typedef struct packed {
        logic [VIDX_BITS-1:0] dense_idx;
        logic                 was_new;
        logic                 table_full;
        logic [VCNT_BITS-1:0] triple_count;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLEAR
    } ctrl_state_t;

    typedef enum logic [1:0] {
        RES_CLEAR,
        RES_HIT,
        RES_INSERT,
        RES_FULL
    } result_op_t;

    typedef struct packed {
        logic       start;
        logic       scan_en;
        logic       result_load;
        result_op_t result_op;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic table_full;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/vertex_triple_dedup_indexer_top.sv -----
// Vertex triple indexer: each item carries one face corner (position, texture
// and normal references) or a clear command, and each produces exactly one
// result. Distinct triples are stored in first-seen order and the result
// gives the dense index of the triple, whether this item inserted it,
// whether a new triple was refused because the table holds 4096 entries,
// and the number of stored triples afterwards. A clear item empties the
// table and returns all zeros. The block works on one item at a time: a
// lookup reads the key store through its single read port, one entry per
// clock, so a found triple ends the scan at its index, while a miss or
// insert reads every stored entry first; an empty table and a clear need
// no read at all. The result sits in an output register, so a new input
// transfer is taken while an earlier result still waits; the block stalls
// only when a new result is ready and the old one has not been taken. The
// key store has no reset: only entries below the stored count are ever
// read.
`default_nettype none

module vertex_triple_dedup_indexer_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire vtdi_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output vtdi_pkg::result_t      result
);

    // Commands from the controller and status back from the datapath.
    vtdi_pkg::dp_cmd_t    cmd;
    vtdi_pkg::dp_status_t sts;

    // The controller sequences accept, scan and result transfer.
    vtdi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .item_ready (item_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    // The datapath holds the key store, the count, the scan pointer and the
    // output register.
    vtdi_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- sv/vtdi_datapath.sv -----
`default_nettype none
`include "vertex_triple_dedup_indexer_top_defines.svh"

module vtdi_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire vtdi_pkg::item_t      item,
    input  wire vtdi_pkg::dp_cmd_t    cmd,
    output vtdi_pkg::dp_status_t      sts,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output vtdi_pkg::result_t         result
);

    // Key store: one write port for inserts, one registered read port for the scan.
    logic [vtdi_pkg::KEY_BITS-1:0] key_store_mem [vtdi_pkg::TABLE_DEPTH];

    logic [vtdi_pkg::KEY_BITS-1:0]  key_reg;
    logic [vtdi_pkg::KEY_BITS-1:0]  rd_data_reg;
    logic [vtdi_pkg::ADDR_BITS-1:0] cmp_idx_reg;
    logic [vtdi_pkg::CNT_BITS-1:0]  entry_count_reg, entry_count_next;
    logic [vtdi_pkg::CNT_BITS-1:0]  scan_idx_reg, scan_idx_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic                           out_valid_reg, out_valid_next;
    vtdi_pkg::result_t              out_item_reg, out_item_next;

    logic issue;
    logic do_insert;

    assign issue     = cmd.scan_en && (scan_idx_reg < entry_count_reg);
    assign do_insert = cmd.result_load && (cmd.result_op == vtdi_pkg::RES_INSERT);

    assign sts.hit        = cmp_valid_reg && (rd_data_reg == key_reg);
    assign sts.scan_done  = !cmp_valid_reg && (scan_idx_reg == entry_count_reg);
    assign sts.table_full = (entry_count_reg == vtdi_pkg::COUNT_FULL);
    assign sts.out_free   = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            key_store_mem[entry_count_reg[vtdi_pkg::ADDR_BITS-1:0]] <= key_reg;
        end
        if (issue)
        begin
            rd_data_reg <= key_store_mem[scan_idx_reg[vtdi_pkg::ADDR_BITS-1:0]];
            cmp_idx_reg <= scan_idx_reg[vtdi_pkg::ADDR_BITS-1:0];
        end
        if (cmd.start)
        begin
            key_reg <= {item.position_index, item.texcoord_index, item.normal_ref};
        end
        if (cmd.result_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_comb
    begin
        scan_idx_next    = scan_idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        entry_count_next = entry_count_reg;
        if (cmd.start || cmd.result_load)
        begin
            scan_idx_next  = '0;
            cmp_valid_next = 1'b0;
        end
        else if (cmd.scan_en)
        begin
            cmp_valid_next = issue;
            if (issue)
            begin
                scan_idx_next = scan_idx_reg + vtdi_pkg::CNT_BITS'(1);
            end
        end
        if (cmd.result_load)
        begin
            if (cmd.result_op == vtdi_pkg::RES_CLEAR)
            begin
                entry_count_next = '0;
            end
            else if (do_insert)
            begin
                entry_count_next = entry_count_reg + vtdi_pkg::CNT_BITS'(1);
            end
        end
        out_valid_next = cmd.result_load ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);
    end

    always_comb
    begin
        out_item_next = '0;
        unique case (cmd.result_op)
            vtdi_pkg::RES_CLEAR:
            begin
                out_item_next = '0;
            end
            vtdi_pkg::RES_HIT:
            begin
                out_item_next.dense_idx    = vtdi_pkg::VIDX_BITS'(cmp_idx_reg);
                out_item_next.triple_count = vtdi_pkg::VCNT_BITS'(entry_count_reg);
            end
            vtdi_pkg::RES_INSERT:
            begin
                out_item_next.dense_idx    = vtdi_pkg::VIDX_BITS'(entry_count_reg);
                out_item_next.was_new      = 1'b1;
                out_item_next.triple_count = vtdi_pkg::VCNT_BITS'(entry_count_next);
            end
            vtdi_pkg::RES_FULL:
            begin
                out_item_next.table_full   = 1'b1;
                out_item_next.triple_count = vtdi_pkg::VCNT_BITS'(entry_count_reg);
            end
            default:
            begin
                out_item_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            scan_idx_reg    <= '0;
            cmp_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            scan_idx_reg    <= scan_idx_next;
            cmp_valid_reg   <= cmp_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // An insert always finds room, and it advances the count by exactly one.
    `VTDI_ASSERT_IMPL(a_insert_room, clk, rst_n, do_insert,
        entry_count_reg < vtdi_pkg::COUNT_FULL)
    `VTDI_ASSERT_NEXT(a_insert_count, clk, rst_n, do_insert,
        entry_count_reg == $past(entry_count_reg) + vtdi_pkg::CNT_BITS'(1))
    // The scan pointer never runs past the stored entries.
    `VTDI_ASSERT_IMPL(a_scan_bound, clk, rst_n, 1'b1, scan_idx_reg <= entry_count_reg)

endmodule

`default_nettype wire

// ----- sv/vtdi_ctrl.sv -----
`default_nettype none
`include "vertex_triple_dedup_indexer_top_defines.svh"

module vtdi_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    input  wire logic                 item_kind,
    output logic                      item_ready,
    output vtdi_pkg::dp_cmd_t         cmd,
    input  wire vtdi_pkg::dp_status_t sts
);

    vtdi_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vtdi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        item_ready    = 1'b0;
        cmd           = '0;
        cmd.result_op = vtdi_pkg::RES_CLEAR;
        unique case (state_reg)
            vtdi_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = (item_kind == vtdi_pkg::KIND_CLEAR) ? vtdi_pkg::ST_CLEAR
                                                                     : vtdi_pkg::ST_SCAN;
                end
            end
            vtdi_pkg::ST_SCAN:
            begin
                if (sts.hit || sts.scan_done)
                begin
                    // Hold the decision until the result register can take it.
                    if (sts.out_free)
                    begin
                        cmd.result_load = 1'b1;
                        priority if (sts.hit)
                        begin
                            cmd.result_op = vtdi_pkg::RES_HIT;
                        end
                        else if (sts.table_full)
                        begin
                            cmd.result_op = vtdi_pkg::RES_FULL;
                        end
                        else
                        begin
                            cmd.result_op = vtdi_pkg::RES_INSERT;
                        end
                        state_next = vtdi_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_en = 1'b1;
                end
            end
            vtdi_pkg::ST_CLEAR:
            begin
                if (sts.out_free)
                begin
                    cmd.result_load = 1'b1;
                    cmd.result_op   = vtdi_pkg::RES_CLEAR;
                    state_next      = vtdi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vtdi_pkg::ST_IDLE;
            end
        endcase
    end

    // A result is only written into a free output register.
    `VTDI_ASSERT_IMPL(a_load_free, clk, rst_n, cmd.result_load, sts.out_free)
    // Work starts only on an input transfer, and input is taken only when idle.
    `VTDI_ASSERT_IMPL(a_start_accept, clk, rst_n, cmd.start, item_valid && item_ready)
    `VTDI_ASSERT_IMPL(a_ready_idle, clk, rst_n, item_ready, state_reg == vtdi_pkg::ST_IDLE)

endmodule

`default_nettype wire
